FILE: rtl/ajp_pkg.sv
// Package for the auto joypad poll sequencer.
// Holds the transaction structs and the step and start-window constants.
// No dependencies.
`timescale 1ns / 1ps

package ajp_pkg;

  localparam int unsigned StepW = 6;
  localparam int unsigned PadW  = 16;
  localparam int unsigned NumPads = 4;

  localparam logic [StepW-1:0] IdleStep  = 6'd33;
  localparam logic [StepW-1:0] LatchStep = 6'd0;
  localparam logic [StepW-1:0] UnlatchStep = 6'd1;
  localparam logic [StepW-1:0] FirstIoStep = 6'd2;
  localparam logic [10:0]      DotLow    = 11'd130;
  localparam logic [10:0]      DotHigh   = 11'd384;

  // one accepted edge
  typedef struct packed {
    logic [8:0]  line;
    logic [10:0] dot;
    logic [8:0]  visible_lines;
    logic        phase_zero;
    logic        cpu_latch;
    logic [1:0]  port1_bits;
    logic [1:0]  port2_bits;
  } in_item_t;

  // per-edge flags of one result transaction
  typedef struct packed {
    logic latch_write;
    logic latch_level;
    logic port_read;
    logic busy;
  } res_flags_t;

  typedef logic [NumPads-1:0][PadW-1:0] pad_bank_t;

endpackage

FILE: rtl/auto_joypad_poll_sequencer_core.sv
// Top level of the auto joypad poll sequencer.
// Holds the poll enable register and joins the input stage and step sequencer.
// Depends on ajp_pkg, ajp_in_reg, ajp_seq.
`timescale 1ns / 1ps

// Takes one transaction per edge and returns exactly one result
// transaction for it. An edge passes an input register and a result register,
// with the combinational step update between them. While out_stall_i is low,
// one edge can be accepted every cycle. A poll runs steps 0 to 33 on
// consecutive edges: latch, unlatch, then alternating port samples and pad
// shifts. poll_enable is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while the block is idle, as the block itself does not enforce it.
module auto_joypad_poll_sequencer_core import ajp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [8:0]  line_i,
  input  logic [10:0] dot_i,
  input  logic [8:0]  visible_lines_i,
  input  logic        phase_zero_i,
  input  logic        cpu_latch_i,
  input  logic [1:0]  port1_bits_i,
  input  logic [1:0]  port2_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        latch_write_o,
  output logic        latch_level_o,
  output logic        port_read_o,
  output logic [15:0] pad1_o,
  output logic [15:0] pad2_o,
  output logic [15:0] pad3_o,
  output logic [15:0] pad4_o,
  output logic        busy_res_o
);

  logic       poll_enable_q, poll_enable_d;
  in_item_t   in_item;
  in_item_t   item;
  logic       item_valid;
  logic       item_take;
  res_flags_t flags;
  pad_bank_t  pads;

  assign poll_enable_d = cfg_we_i ? cfg_wdata_i : poll_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_enable_q <= 1'b0;
    end else begin
      poll_enable_q <= poll_enable_d;
    end
  end

  assign in_item.line          = line_i;
  assign in_item.dot           = dot_i;
  assign in_item.visible_lines = visible_lines_i;
  assign in_item.phase_zero    = phase_zero_i;
  assign in_item.cpu_latch     = cpu_latch_i;
  assign in_item.port1_bits    = port1_bits_i;
  assign in_item.port2_bits    = port2_bits_i;

  ajp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  ajp_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .poll_enable_i (poll_enable_q),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_take_o   (item_take),
    .res_valid_o   (out_valid_o),
    .res_stall_i   (out_stall_i),
    .res_flags_o   (flags),
    .pads_o        (pads)
  );

  assign latch_write_o = flags.latch_write;
  assign latch_level_o = flags.latch_level;
  assign port_read_o   = flags.port_read;
  assign busy_res_o    = flags.busy;
  assign pad1_o        = pads[0];
  assign pad2_o        = pads[1];
  assign pad3_o        = pads[2];
  assign pad4_o        = pads[3];

endmodule

FILE: rtl/ajp_in_reg.sv
// Input register stage of the auto joypad poll sequencer.
// Captures one edge transaction and holds it until the step logic takes it.
// Depends on ajp_pkg.
`timescale 1ns / 1ps

module ajp_in_reg import ajp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     item_valid_o,
  output in_item_t item_o,
  input  logic     item_take_i
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  // stage is free when empty or being drained this cycle
  assign in_stall_o = valid_q && !item_take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

FILE: rtl/ajp_seq.sv
// Step sequencer of the auto joypad poll sequencer: step counter, port
// samples, the four pad shift registers and the result register.
// Depends on ajp_pkg.
`timescale 1ns / 1ps

module ajp_seq import ajp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       poll_enable_i,
  input  logic       item_valid_i,
  input  in_item_t   item_i,
  output logic       item_take_o,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output res_flags_t res_flags_o,
  output pad_bank_t  pads_o
);

  logic [StepW-1:0] step_q, step_d;
  logic [1:0]       samp1_q, samp1_d;
  logic [1:0]       samp2_q, samp2_d;
  pad_bank_t        pad_q, pad_d;
  res_flags_t       flags_q, flags_d;
  logic             res_valid_q, res_valid_d;
  logic             start;
  logic             active;

  assign item_take_o = item_valid_i && (!res_valid_q || !res_stall_i);

  assign start = (item_i.line == item_i.visible_lines) && item_i.phase_zero &&
                 (item_i.dot >= DotLow) && (item_i.dot <= DotHigh);

  always_comb begin
    step_d  = step_q;
    samp1_d = samp1_q;
    samp2_d = samp2_q;
    pad_d   = pad_q;
    flags_d = '0;
    active  = 1'b1;

    if (start) begin
      step_d = LatchStep;
    end else if (step_q >= IdleStep) begin
      active = 1'b0;
    end else begin
      step_d = step_q + 6'd1;
    end

    if (active) begin
      if (step_d == LatchStep) begin
        flags_d.latch_write = 1'b1;
        flags_d.latch_level = poll_enable_i | item_i.cpu_latch;
        if (poll_enable_i) begin
          pad_d = '0;
        end
      end
      if (step_d == UnlatchStep) begin
        flags_d.latch_write = 1'b1;
        flags_d.latch_level = item_i.cpu_latch;
      end
      // disable aborts everywhere except the unlatch step
      if (step_d != UnlatchStep && !poll_enable_i) begin
        step_d = IdleStep;
      end else if (step_d >= FirstIoStep) begin
        if (!step_d[0]) begin
          samp1_d = item_i.port1_bits;
          samp2_d = item_i.port2_bits;
          flags_d.port_read = 1'b1;
        end else begin
          pad_d[0] = {pad_q[0][PadW-2:0], samp1_q[0]};
          pad_d[1] = {pad_q[1][PadW-2:0], samp2_q[0]};
          pad_d[2] = {pad_q[2][PadW-2:0], samp1_q[1]};
          pad_d[3] = {pad_q[3][PadW-2:0], samp2_q[1]};
        end
      end
    end

    flags_d.busy = (step_d < IdleStep);
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (item_take_o) begin
      res_valid_d = 1'b1;
    end else if (!res_stall_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= IdleStep;
      samp1_q     <= '0;
      samp2_q     <= '0;
      pad_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (item_take_o) begin
        step_q  <= step_d;
        samp1_q <= samp1_d;
        samp2_q <= samp2_d;
        pad_q   <= pad_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      flags_q <= flags_d;
    end
  end

  // pad registers update only together with the result, so they are the result
  assign res_valid_o = res_valid_q;
  assign res_flags_o = flags_q;
  assign pads_o      = pad_q;

`ifndef ASSERT_OFF
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= IdleStep)
    else $error("step counter beyond idle");

  a_busy_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (flags_q.busy == (step_q < IdleStep)))
    else $error("busy flag disagrees with step counter");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && flags_q.port_read) |-> (flags_q.busy && !flags_q.latch_write))
    else $error("port read outside an active poll or during latch");

  a_level_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && flags_q.latch_level) |-> flags_q.latch_write)
    else $error("latch level without latch write");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!item_take_o) |=> ($stable(step_q) && $stable(pad_q)))
    else $error("sequencer state moved without a transaction");
`endif

endmodule
